// ----- sv/grc_pkg.sv -----
package grc_pkg;

   // Divider operand widths: 42-bit dividend (screen height << 31), 22-bit divisor
   localparam int DIV_NW = 42;
   localparam int DIV_DW = 22;

   // Signed Q32 point accumulator width
   localparam int PW = 44;

   localparam longint unsigned Q30_ONE     = 64'h4000_0000;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   localparam logic [15:0] QUARTER_TURN = 16'd16384;

   typedef enum logic [3:0] {
      REG_PLAYER_X      = 4'd0,
      REG_PLAYER_Y      = 4'd1,
      REG_VIEW_ANGLE    = 4'd2,
      REG_FIELD_OF_VIEW = 4'd3,
      REG_DEPTH_LIMIT   = 4'd4,
      REG_MARCH_STEP    = 4'd5,
      REG_SCREEN_WIDTH  = 4'd6,
      REG_SCREEN_HEIGHT = 4'd7
   } grc_reg_type;

   typedef enum logic [0:0] {
      KIND_TILE_WRITE = 1'b0,
      KIND_CAST       = 1'b1
   } grc_kind_type;

   typedef enum logic [1:0] {
      ROM_RAY = 2'd0,
      ROM_EY  = 2'd1,
      ROM_COS = 2'd2
   } grc_rom_sel_type;

   typedef struct packed {
      logic            clr_step;
      logic            tile_wr;
      logic            cast_load;
      logic            ray_set;
      grc_rom_sel_type rom_sel;
      logic            ex_load;
      logic            ey_load;
      logic            march_init;
      logic            march_adv;
      logic            hit_take;
      logic            fish;
      logic            proj_start;
      logic            out_load;
   } grc_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic div_done;
      logic dist_done;
      logic off_map;
      logic tile_nz;
      logic dist_zero;
      logic rsp_busy;
   } grc_sts_type;

endpackage

// ----- sv/grc_div.sv -----
module grc_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [grc_pkg::DIV_NW-1:0] dividend,
   input  logic [grc_pkg::DIV_DW-1:0] divisor,
   output logic                       done,
   output logic [grc_pkg::DIV_NW-1:0] quotient
);

   localparam int CNTW = $clog2(grc_pkg::DIV_NW + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;
   logic [grc_pkg::DIV_NW-1:0] quo_ff, quo_in;
   logic [grc_pkg::DIV_DW-1:0] rem_ff, rem_in;
   logic [grc_pkg::DIV_DW-1:0] div_ff, div_in;
   logic [grc_pkg::DIV_DW:0]   trial;
   logic                       take;

   // One quotient bit per cycle, restoring
   always_comb begin
      trial   = {rem_ff, quo_ff[grc_pkg::DIV_NW-1]};
      take    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(grc_pkg::DIV_NW);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[grc_pkg::DIV_NW-2:0], take};
         rem_in = take ? grc_pkg::DIV_DW'(trial - {1'b0, div_ff})
                       : trial[grc_pkg::DIV_DW-1:0];
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/grc_dpath.sv -----
module grc_dpath #(
   parameter int MAP_DIM      = 32,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  grc_pkg::grc_cmd_type cmd,
   output grc_pkg::grc_sts_type sts,
   input  logic                csr_valid,
   input  logic [3:0]          csr_index,
   input  logic [21:0]         csr_data,
   input  logic [4:0]          req_tile_col,
   input  logic [4:0]          req_tile_row,
   input  logic [3:0]          req_tile_value,
   input  logic [9:0]          req_column,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [9:0]          rsp_column_out,
   output logic                rsp_hit,
   output logic [3:0]          rsp_hit_tile,
   output logic                rsp_face,
   output logic [15:0]         rsp_texture_u,
   output logic [21:0]         rsp_distance,
   output logic signed [11:0]  rsp_wall_top,
   output logic [11:0]         rsp_wall_height
);

   localparam int AW    = $clog2(MAP_DIM);
   localparam int CW    = 2 * AW;
   localparam int DEPTH = 1 << CW;
   localparam int KW    = $clog2(SINE_ENTRIES);
   localparam int PW    = grc_pkg::PW;

   typedef logic signed [17:0] sine_rom_type [SINE_ENTRIES];

   function automatic logic signed [17:0] sine_entry(int unsigned k);
      longint unsigned p;
      longint unsigned r;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned v;
      logic [1:0]      quad;
      p    = (longint'(k) << 32) / SINE_ENTRIES;
      quad = p[31:30];
      r    = p & (grc_pkg::Q30_ONE - 1);
      if (quad[0])
         r = grc_pkg::Q30_ONE - r;
      x  = (r * grc_pkg::HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      t  = grc_pkg::Q30_ONE;
      t  = grc_pkg::Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = grc_pkg::Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = grc_pkg::Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = grc_pkg::Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = grc_pkg::Q30_ONE - ((x2 * t) >> 30) / 6;
      v  = (((x * t) >> 30) + 8192) >> 14;
      return quad[1] ? -18'(v) : 18'(v);
   endfunction

   function automatic sine_rom_type build_sine();
      sine_rom_type tab;
      for (int k = 0; k < SINE_ENTRIES; k++)
         tab[k] = sine_entry(k);
      return tab;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine();

   // Configuration
   logic [20:0] player_x_ff, player_y_ff;
   logic [15:0] view_ff;
   logic [14:0] fov_ff;
   logic [21:0] depth_ff;
   logic [15:0] step_ff;
   logic [10:0] width_ff, height_ff;

   // Tile store
   logic [3:0]    tile_mem [DEPTH];
   logic [3:0]    tile_q_ff;
   logic [CW-1:0] clr_ff;
   logic [CW-1:0] rd_addr;
   logic [6:0]    wr_col, wr_row;

   // Cast state
   logic [9:0]               col_ff;
   logic [15:0]              ray_ff;
   logic [15:0]              rom_ang;
   logic [KW+16:0]           rom_mul;
   logic [KW-1:0]            rom_k;
   logic signed [17:0]       rom_q_ff, ex_ff, ey_ff, c_ff;
   logic [15:0]              step_eff;
   logic signed [34:0]       stepx_ff, stepy_ff;
   logic signed [PW-1:0]     px_ff, py_ff;
   logic [22:0]              dist_ff;
   logic                     hit_ff, face_ff;
   logic [3:0]               tile_ff;
   logic [15:0]              u_ff;
   logic [21:0]              dq_ff;

   // Hit classification
   logic [15:0]        fx, fy;
   logic signed [16:0] dx, dy;
   logic [16:0]        ax, ay;
   logic               face_w;

   // Fisheye and projection
   logic [39:0]          fish_prod;
   logic [21:0]          fish_d;
   logic                 div_start, div_done;
   logic [grc_pkg::DIV_NW-1:0] div_nd, div_q;
   logic [grc_pkg::DIV_DW-1:0] div_dv;
   logic [11:0]          hv_w;
   logic signed [PW-1:0] tq, rows_full;
   logic signed [11:0]   rows_w;
   logic [10:0]          width_eff;

   logic                 rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff <= 21'd524288;
         player_y_ff <= 21'd524288;
         view_ff     <= 16'd0;
         fov_ff      <= 15'd13107;
         depth_ff    <= 22'd1966080;
         step_ff     <= 16'd655;
         width_ff    <= 11'd640;
         height_ff   <= 11'd480;
      end else if (csr_valid) begin
         case (csr_index)
            grc_pkg::REG_PLAYER_X:      player_x_ff <= csr_data[20:0];
            grc_pkg::REG_PLAYER_Y:      player_y_ff <= csr_data[20:0];
            grc_pkg::REG_VIEW_ANGLE:    view_ff     <= csr_data[15:0];
            grc_pkg::REG_FIELD_OF_VIEW: fov_ff      <= csr_data[14:0];
            grc_pkg::REG_DEPTH_LIMIT:   depth_ff    <= csr_data;
            grc_pkg::REG_MARCH_STEP:    step_ff     <= csr_data[15:0];
            grc_pkg::REG_SCREEN_WIDTH:  width_ff    <= csr_data[10:0];
            grc_pkg::REG_SCREEN_HEIGHT: height_ff   <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   // Tile store: clearing pass after reset, then single writes
   assign wr_col  = {2'b00, req_tile_col};
   assign wr_row  = {2'b00, req_tile_row};
   assign rd_addr = {py_ff[32+AW-1:32], px_ff[32+AW-1:32]};

   always_ff @(posedge clock) begin
      if (reset)
         clr_ff <= '0;
      else if (cmd.clr_step)
         clr_ff <= clr_ff + CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step)
         tile_mem[clr_ff] <= 4'd0;
      else if (cmd.tile_wr && (32'(wr_col) < MAP_DIM) && (32'(wr_row) < MAP_DIM))
         tile_mem[{wr_row[AW-1:0], wr_col[AW-1:0]}] <= req_tile_value;
      tile_q_ff <= tile_mem[rd_addr];
   end

   // Sine table lookup
   always_comb begin
      case (cmd.rom_sel)
         grc_pkg::ROM_RAY: rom_ang = ray_ff;
         grc_pkg::ROM_EY:  rom_ang = ray_ff + grc_pkg::QUARTER_TURN;
         grc_pkg::ROM_COS: rom_ang = ray_ff - view_ff + grc_pkg::QUARTER_TURN;
         default:          rom_ang = ray_ff;
      endcase
      rom_mul = {{(KW+1){1'b0}}, rom_ang} * (KW+17)'(SINE_ENTRIES);
      rom_k   = rom_mul[KW+15:16];
   end

   always_ff @(posedge clock)
      rom_q_ff <= SINE_ROM[rom_k];

   // Shared divider: ray angle offset, then wall projection
   assign width_eff = (width_ff == 11'd0) ? 11'd1 : width_ff;
   assign div_start = cmd.cast_load | cmd.proj_start;
   assign div_nd    = cmd.cast_load
                      ? grc_pkg::DIV_NW'(25'(req_column) * 25'(fov_ff))
                      : {height_ff, 31'd0};
   assign div_dv    = cmd.cast_load ? grc_pkg::DIV_DW'(width_eff) : dq_ff;

   grc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_nd),
      .divisor  (div_dv),
      .done     (div_done),
      .quotient (div_q)
   );

   assign step_eff = (step_ff == 16'd0) ? 16'd1 : step_ff;

   always_comb begin
      fx = px_ff[31:16];
      fy = py_ff[31:16];
      dx = $signed({1'b0, fx}) - 17'sd32768;
      dy = $signed({1'b0, fy}) - 17'sd32768;
      ax = dx[16] ? 17'(-dx) : 17'(dx);
      ay = dy[16] ? 17'(-dy) : 17'(dy);
      if (ax > ay)
         face_w = 1'b1;
      else if (ay > ax)
         face_w = 1'b0;
      else
         face_w = !((dx == dy) && (dx != 17'sd0));
   end

   always_comb begin
      fish_prod = {17'd0, dist_ff} * {23'd0, c_ff[16:0]};
      if (c_ff[17] || (c_ff == 18'sd0))
         fish_d = 22'd0;
      else if (fish_prod[39:38] != 2'b00)
         fish_d = 22'h3F_FFFF;
      else
         fish_d = fish_prod[37:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.cast_load)
         col_ff <= req_column;
      if (cmd.ray_set)
         ray_ff <= view_ff - {2'b00, fov_ff[14:1]} + div_q[15:0];
      if (cmd.ex_load)
         ex_ff <= rom_q_ff;
      if (cmd.ey_load)
         ey_ff <= rom_q_ff;
      if (cmd.march_init) begin
         c_ff     <= rom_q_ff;
         stepx_ff <= ex_ff * $signed({2'b00, step_eff});
         stepy_ff <= ey_ff * $signed({2'b00, step_eff});
         px_ff    <= $signed({7'd0, player_x_ff, 16'd0});
         py_ff    <= $signed({7'd0, player_y_ff, 16'd0});
         dist_ff  <= 23'd0;
      end
      if (cmd.march_adv) begin
         dist_ff <= dist_ff + 23'(step_eff);
         px_ff   <= px_ff + {{(PW-35){stepx_ff[34]}}, stepx_ff};
         py_ff   <= py_ff + {{(PW-35){stepy_ff[34]}}, stepy_ff};
      end
      if (cmd.hit_take) begin
         tile_ff <= tile_q_ff;
         face_ff <= face_w;
         u_ff    <= face_w ? fy : fx;
      end
      if (cmd.fish)
         dq_ff <= hit_ff ? fish_d : depth_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         hit_ff <= 1'b0;
      else if (cmd.march_init)
         hit_ff <= 1'b0;
      else if (cmd.hit_take)
         hit_ff <= 1'b1;
   end

   // Wall slice from the quotient (height << 31) / distance
   always_comb begin
      hv_w      = (div_q[41:27] != 15'd0) ? 12'd4095 : div_q[26:15];
      tq        = $signed({18'd0, height_ff, 15'd0}) - $signed({2'b00, div_q});
      rows_full = tq[PW-1] ? -(PW'((-tq) >>> 16)) : (tq >>> 16);
      if (rows_full > 44'sd2047)
         rows_w = 12'sd2047;
      else if (rows_full < -44'sd2048)
         rows_w = -12'sd2048;
      else
         rows_w = rows_full[11:0];
      if (dq_ff == 22'd0) begin
         hv_w   = (height_ff == 11'd0) ? 12'd0 : 12'd4095;
         rows_w = (height_ff == 11'd0) ? 12'sd0 : -12'sd2048;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.out_load)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         rsp_column_out  <= col_ff;
         rsp_hit         <= hit_ff;
         rsp_hit_tile    <= hit_ff ? tile_ff : 4'd0;
         rsp_face        <= hit_ff & face_ff;
         rsp_texture_u   <= hit_ff ? u_ff : 16'd0;
         rsp_distance    <= dq_ff;
         rsp_wall_top    <= rows_w;
         rsp_wall_height <= hv_w;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sts.clr_last  = (clr_ff == {CW{1'b1}});
      sts.div_done  = div_done;
      sts.dist_done = (dist_ff >= {1'b0, depth_ff});
      sts.off_map   = px_ff[PW-1] | py_ff[PW-1]
                      | (32'(px_ff[PW-2:32]) >= MAP_DIM)
                      | (32'(py_ff[PW-2:32]) >= MAP_DIM);
      sts.tile_nz   = (tile_q_ff != 4'd0);
      sts.dist_zero = (dq_ff == 22'd0);
      sts.rsp_busy  = rsp_valid_ff & rsp_stall;
   end

endmodule

// ----- sv/grc_ctrl.sv -----
module grc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   output grc_pkg::grc_cmd_type cmd,
   input  grc_pkg::grc_sts_type sts
);

   typedef enum logic [13:0] {
      S_CLR  = 14'b00000000000001,
      S_IDLE = 14'b00000000000010,
      S_ADIV = 14'b00000000000100,
      S_SX   = 14'b00000000001000,
      S_SY   = 14'b00000000010000,
      S_SC   = 14'b00000000100000,
      S_PREP = 14'b00000001000000,
      S_STEP = 14'b00000010000000,
      S_LOOK = 14'b00000100000000,
      S_TEST = 14'b00001000000000,
      S_FISH = 14'b00010000000000,
      S_PROJ = 14'b00100000000000,
      S_PDIV = 14'b01000000000000,
      S_FIN  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rom_sel = grc_pkg::ROM_RAY;
      case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last)
               state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_kind == grc_pkg::KIND_CAST) begin
                  cmd.cast_load = 1'b1;
                  state_in      = S_ADIV;
               end else begin
                  cmd.tile_wr = 1'b1;
               end
            end
         end
         S_ADIV: begin
            if (sts.div_done) begin
               cmd.ray_set = 1'b1;
               state_in    = S_SX;
            end
         end
         S_SX: begin
            cmd.rom_sel = grc_pkg::ROM_RAY;
            state_in    = S_SY;
         end
         S_SY: begin
            cmd.ex_load = 1'b1;
            cmd.rom_sel = grc_pkg::ROM_EY;
            state_in    = S_SC;
         end
         S_SC: begin
            cmd.ey_load = 1'b1;
            cmd.rom_sel = grc_pkg::ROM_COS;
            state_in    = S_PREP;
         end
         S_PREP: begin
            cmd.march_init = 1'b1;
            state_in       = S_STEP;
         end
         S_STEP: begin
            if (sts.dist_done) begin
               state_in = S_FISH;
            end else begin
               cmd.march_adv = 1'b1;
               state_in      = S_LOOK;
            end
         end
         S_LOOK: begin
            // tile read is under way for the new point
            state_in = sts.off_map ? S_FISH : S_TEST;
         end
         S_TEST: begin
            if (sts.tile_nz) begin
               cmd.hit_take = 1'b1;
               state_in     = S_FISH;
            end else if (sts.dist_done) begin
               state_in = S_FISH;
            end else begin
               cmd.march_adv = 1'b1;
               state_in      = S_LOOK;
            end
         end
         S_FISH: begin
            cmd.fish = 1'b1;
            state_in = S_PROJ;
         end
         S_PROJ: begin
            if (sts.dist_zero) begin
               state_in = S_FIN;
            end else begin
               cmd.proj_start = 1'b1;
               state_in       = S_PDIV;
            end
         end
         S_PDIV: begin
            if (sts.div_done)
               state_in = S_FIN;
         end
         S_FIN: begin
            // hold until the output register can take the beat
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_CLR;
      else
         state_ff <= state_in;
   end

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> (state_ff == S_ADIV || state_ff == S_PDIV))
      else $error("divider finished outside a wait state");

   a_test_after_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST) |-> ($past(state_ff) == S_LOOK))
      else $error("tile tested without a read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> !$past(sts.rsp_busy))
      else $error("result loaded over a stalled beat");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !accept)
      else $error("item taken during clearing pass");

endmodule

// ----- sv/grid_raycast_column.sv -----
// Channel  Direction  Handshake             Beat
// req      in         req_valid/req_stall   tile write or column cast
// rsp      out        rsp_valid/rsp_stall   one result per cast
// csr      in         csr_valid/csr_ready   register index and data
//
// Requests: a tile write leaves the block idle; a cast holds req_stall high until its
// result is loaded, its length set by the march loop (one tile store read per step) and
// the shared divider (ray angle, then wall projection unless the distance is zero).
// Reset: after reset the tile store is cleared, one entry per cycle, over every entry
// (MAP_DIM rounded up to a power of two per side); no item is taken then.
// Stalls: a finished result waits in the output register while rsp_stall is high.
module grid_raycast_column #(
   parameter int MAP_DIM      = 32,
   parameter int SINE_ENTRIES = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_kind,
   input  logic [4:0]         req_tile_col,
   input  logic [4:0]         req_tile_row,
   input  logic [3:0]         req_tile_value,
   input  logic [9:0]         req_column,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [9:0]         rsp_column_out,
   output logic               rsp_hit,
   output logic [3:0]         rsp_hit_tile,
   output logic               rsp_face,
   output logic [15:0]        rsp_texture_u,
   output logic [21:0]        rsp_distance,
   output logic signed [11:0] rsp_wall_top,
   output logic [11:0]        rsp_wall_height,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [21:0]        csr_data
);

   grc_pkg::grc_cmd_type cmd;
   grc_pkg::grc_sts_type sts;

   assign csr_ready = 1'b1;

   grc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .cmd       (cmd),
      .sts       (sts)
   );

   grc_dpath #(
      .MAP_DIM      (MAP_DIM),
      .SINE_ENTRIES (SINE_ENTRIES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr_valid       (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_tile_col    (req_tile_col),
      .req_tile_row    (req_tile_row),
      .req_tile_value  (req_tile_value),
      .req_column      (req_column),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_column_out  (rsp_column_out),
      .rsp_hit         (rsp_hit),
      .rsp_hit_tile    (rsp_hit_tile),
      .rsp_face        (rsp_face),
      .rsp_texture_u   (rsp_texture_u),
      .rsp_distance    (rsp_distance),
      .rsp_wall_top    (rsp_wall_top),
      .rsp_wall_height (rsp_wall_height)
   );

endmodule
